// ===== src/crws_pkg.sv =====
// crws_pkg: sizes, constants and types of the command rate window statistics block
// no dependencies; imported by the channel interfaces, the core and its checker
package crws_pkg;

  localparam int RING_DEPTH   = 64;
  localparam int CLIENT_COUNT = 32;
  localparam int WINDOW_MS    = 1000;

  localparam int CLIENT_W = 5;
  localparam int FIELD_W  = 31;
  localparam int COUNT_W  = 7;

  localparam int CLIENTS   = (CLIENT_COUNT < (1 << CLIENT_W)) ? CLIENT_COUNT : (1 << CLIENT_W);
  localparam int CLIENT_IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int SLOT_W    = $clog2(RING_DEPTH);
  localparam int MEM_DEPTH = CLIENTS * RING_DEPTH;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SUM_W     = FIELD_W + 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [CLIENT_W-1:0] cid_t;
  typedef logic [FIELD_W-1:0]  field_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [MEM_AW-1:0]   mem_addr_t;

  typedef struct packed {
    field_t tag;
    field_t stamp;
  } entry_t;

  typedef struct packed {
    logic  valid;
    slot_t slot;
  } rd_stage_t;

  function automatic count_t sat_inc(count_t c);
    return (c == COUNT_MAX) ? c : c + count_t'(1);
  endfunction

endpackage

// ===== src/crws_stream_if.sv =====
// crws_cmd_if and crws_stat_if: valid/ready channels of the block
// depends on crws_pkg for the payload types
interface crws_cmd_if import crws_pkg::*; ();
  logic    valid;
  logic    ready;
  cid_t    client_id;
  field_t  command_time;
  field_t  packet_tag;

  modport source (output valid, client_id, command_time, packet_tag, input ready);
  modport sink (input valid, client_id, command_time, packet_tag, output ready);
endinterface

interface crws_stat_if import crws_pkg::*; ();
  logic    valid;
  logic    ready;
  cid_t    client_echo;
  count_t  commands_in_window;
  count_t  packets_in_window;

  modport source (output valid, client_echo, commands_in_window, packets_in_window,
                  input ready);
  modport sink (input valid, client_echo, commands_in_window, packets_in_window,
                output ready);
endinterface

// ===== src/command_rate_window_stats_core.sv =====
// command_rate_window_stats_core: per-client command ring and one-second window counts
// depends on crws_pkg and the channel interfaces in crws_stream_if.sv
//
//   channel   dir   transfer moves
//   in_cmd    in    client_id, command_time, packet_tag
//   out_stat  out   client_echo, commands_in_window, packets_in_window
//
// each item is written on acceptance, then its ring is read one slot per cycle
// from the entry memory in ST_SCAN, ST_FLUSH folds the last read, ST_FINISH loads the output
// in_cmd.ready is high only while the sequencer is idle
// a waiting result sits in the output register while the next item is taken
// reset is synchronous; a per-client write pointer and full flag make unwritten slots read as zero
// a stalled result holds the sequencer in its final state until out_stat.ready
module command_rate_window_stats_core import crws_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  crws_cmd_if.sink       in_cmd,
  crws_stat_if.source    out_stat
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FLUSH  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_r, state_nxt;

  entry_t mem [MEM_DEPTH];
  entry_t rd_data_r;

  slot_t  write_slot_r [CLIENTS];
  logic   full_r [CLIENTS];

  cid_t      client_r;
  field_t    now_r;
  slot_t     cur_slot_r;
  logic      cur_full_r;
  slot_t     idx_r, idx_nxt;
  rd_stage_t rd_r, rd_nxt;
  count_t    cmds_r, cmds_nxt;
  count_t    pkts_r, pkts_nxt;
  field_t    last_tag_r, last_tag_nxt;

  logic      out_valid_r;
  cid_t      out_client_r;
  count_t    out_cmds_r;
  count_t    out_pkts_r;

  logic      in_fire;
  logic      in_range;
  logic [CLIENT_IW-1:0] in_cidx;
  logic [CLIENT_IW-1:0] cidx;
  slot_t     new_slot;
  logic      new_full;
  mem_addr_t wr_addr;
  mem_addr_t rd_addr;
  logic      rd_en;
  logic      entry_ok;
  field_t    stamp_v;
  field_t    tag_v;
  logic [SUM_W-1:0] reach;
  logic      in_window;
  logic      out_load;

  assign in_cmd.ready = (state_r == ST_IDLE);
  assign in_fire      = in_cmd.valid && in_cmd.ready;
  assign in_range     = (32'(in_cmd.client_id) < 32'(CLIENT_COUNT));
  assign in_cidx      = in_cmd.client_id[CLIENT_IW-1:0];
  assign cidx         = client_r[CLIENT_IW-1:0];

  assign new_slot = (write_slot_r[in_cidx] == slot_t'(RING_DEPTH - 1)) ? '0
                    : write_slot_r[in_cidx] + slot_t'(1);
  assign new_full = full_r[in_cidx] || (new_slot == '0);

  assign wr_addr = mem_addr_t'(in_cidx) * mem_addr_t'(RING_DEPTH) + mem_addr_t'(new_slot);
  assign rd_addr = mem_addr_t'(cidx) * mem_addr_t'(RING_DEPTH) + mem_addr_t'(idx_r);
  assign rd_en   = (state_r == ST_SCAN);

  always_ff @(posedge clk) begin
    if (in_fire && in_range) begin
      mem[wr_addr] <= '{tag: in_cmd.packet_tag, stamp: in_cmd.command_time};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // slot reads as written only once the ring pointer has passed it
  assign entry_ok  = cur_full_r || ((rd_r.slot != '0) && (rd_r.slot <= cur_slot_r));
  assign stamp_v   = entry_ok ? rd_data_r.stamp : '0;
  assign tag_v     = entry_ok ? rd_data_r.tag : '0;
  assign reach     = SUM_W'(stamp_v) + SUM_W'(WINDOW_MS);
  assign in_window = (reach >= SUM_W'(now_r));

  assign out_load  = (state_r == ST_FINISH) && (!out_valid_r || out_stat.ready);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    rd_nxt       = '{valid: 1'b0, slot: idx_r};
    cmds_nxt     = cmds_r;
    pkts_nxt     = pkts_r;
    last_tag_nxt = last_tag_r;

    if (rd_r.valid && in_window) begin
      cmds_nxt = sat_inc(cmds_r);
      if (tag_v != last_tag_r) begin
        last_tag_nxt = tag_v;
        pkts_nxt     = sat_inc(pkts_r);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt      = '0;
          cmds_nxt     = '0;
          pkts_nxt     = '0;
          last_tag_nxt = '0;
          state_nxt    = in_range ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        rd_nxt.valid = 1'b1;
        if (idx_r == slot_t'(RING_DEPTH - 1)) begin
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt = idx_r + slot_t'(1);
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CLIENTS; i++) begin
        write_slot_r[i] <= '0;
        full_r[i]       <= 1'b0;
      end
    end else begin
      state_r    <= state_nxt;
      rd_r       <= rd_nxt;
      if (in_fire && in_range) begin
        write_slot_r[in_cidx] <= new_slot;
        full_r[in_cidx]       <= new_full;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_stat.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cmds_r     <= cmds_nxt;
    pkts_r     <= pkts_nxt;
    last_tag_r <= last_tag_nxt;
    if (in_fire) begin
      client_r   <= in_cmd.client_id;
      now_r      <= in_cmd.command_time;
      cur_slot_r <= new_slot;
      cur_full_r <= new_full;
    end
    if (out_load) begin
      out_client_r <= client_r;
      out_cmds_r   <= cmds_r;
      out_pkts_r   <= pkts_r;
    end
  end

  assign out_stat.valid              = out_valid_r;
  assign out_stat.client_echo        = out_client_r;
  assign out_stat.commands_in_window = out_cmds_r;
  assign out_stat.packets_in_window  = out_pkts_r;

endmodule

// ===== src/crws_checker.sv =====
// crws_checker: port-level assertions for command_rate_window_stats_core
// depends on crws_pkg; attached to the core by the bind statement below
module crws_checker import crws_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input cid_t    out_client,
  input count_t  out_cmds,
  input count_t  out_pkts
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_client) && $stable(out_cmds)
      && $stable(out_pkts))
    else $error("result changed while stalled");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_pkts_le_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pkts <= out_cmds)
    else $error("packet count above command count");

  a_cmds_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_cmds) <= RING_DEPTH)
    else $error("command count above ring depth");

endmodule

bind command_rate_window_stats_core crws_checker u_crws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_cmd.valid),
  .in_ready   (in_cmd.ready),
  .out_valid  (out_stat.valid),
  .out_ready  (out_stat.ready),
  .out_client (out_stat.client_echo),
  .out_cmds   (out_stat.commands_in_window),
  .out_pkts   (out_stat.packets_in_window)
);
